/* rtl/core/lidar_point_to_pixel_projection_unit_defines.svh */
// Assertion macros for the lidar projection unit.
// No dependencies.
`ifndef LIDAR_POINT_TO_PIXEL_PROJECTION_UNIT_DEFINES_SVH
`define LIDAR_POINT_TO_PIXEL_PROJECTION_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LPP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define LPP_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPP_ASSERT(lbl, clk, rstn, prop, msg)
`define LPP_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

/* rtl/core/lpp_pkg.sv */
// Shared types and constants for the lidar projection unit.
// No dependencies.
`timescale 1ns / 1ps
package lpp_pkg;
  localparam int unsigned RegW          = 28;
  localparam int unsigned PixW          = 16;
  localparam int unsigned CoordFracBits = 16;

  typedef enum logic [1:0] {
    REG_FOCAL_X  = 2'd0,
    REG_FOCAL_Y  = 2'd1,
    REG_CENTER_X = 2'd2,
    REG_CENTER_Y = 2'd3
  } reg_idx_e;

  // rotation Q2.30, row major
  localparam logic signed [31:0] ROT [9] = '{
    -32'sd7720938 - 32'sd60, -32'sd1073711136, -32'sd2505695,
     32'sd11268867,           32'sd2424595,    -32'sd1073679955,
     32'sd1073654926,        -32'sd7746854,     32'sd11251118
  };
  // translation Q16.16
  localparam logic signed [31:0] TRANS [3] = '{
    -32'sd1119, 32'sd11280, -32'sd7326
  };

  // divider lane payload
  typedef struct packed {
    logic signed [62:0] rem;   // remainder magnitude workspace
    logic [15:0]        quo;
    logic               neg;
    logic               sat;
  } lane_t;
endpackage

/* rtl/core/lpp_xform.sv */
// Rigid transform: registered stages of products and sums.
// Depends on lpp_pkg.
`timescale 1ns / 1ps
module lpp_xform import lpp_pkg::*; (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [31:0]        px_i,
  input  logic signed [31:0]        py_i,
  input  logic signed [31:0]        pz_i,
  output logic signed [33:0]        xc_o,
  output logic signed [33:0]        yc_o,
  output logic signed [33:0]        zc_o
);
  logic signed [63:0] prod_q [9];
  logic signed [65:0] acc_q [3];
  logic signed [31:0] p [3];
  assign p[0] = px_i;
  assign p[1] = py_i;
  assign p[2] = pz_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) prod_q[3*r+c] <= ROT[3*r+c] * p[c];
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        acc_q[r] <= 66'(prod_q[3*r]) + 66'(prod_q[3*r+1]) + 66'(prod_q[3*r+2])
                  + ((66'(TRANS[r])) <<< (CoordFracBits + 14));
      end
    end
  end
  assign xc_o = 34'(acc_q[0] >>> 30);
  assign yc_o = 34'(acc_q[1] >>> 30);
  assign zc_o = 34'(acc_q[2] >>> 30);
endmodule

/* rtl/core/lpp_div_cell.sv */
// One cell of the restoring divider chain: produces one quotient bit.
// Depends on lpp_pkg.
`timescale 1ns / 1ps
module lpp_div_cell import lpp_pkg::*; #(
  parameter int unsigned Shift = 0
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  lane_t       lane_i,
  input  logic [48:0] den_i,
  output lane_t       lane_o
);
  lane_t       nxt;
  logic [63:0] trial;
  always_comb begin
    nxt   = lane_i;
    trial = 64'(den_i) << Shift;
    if (!lane_i.sat && 64'(unsigned'(lane_i.rem)) >= trial) begin
      nxt.rem = lane_i.rem - 63'(trial);
      nxt.quo = lane_i.quo | 16'(16'd1 << Shift);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) lane_o <= nxt;
  end
endmodule

/* rtl/core/lidar_point_to_pixel_projection_unit.sv */
// Top level: lidar point to camera pixel projection, fully pipelined.
// Depends on lpp_pkg, lpp_xform, lpp_div_cell and the defines header.
//
// Channel | dir | fields (low bit first)
// s_axis  | in  | tdata: point_x, point_y, point_z; tuser: cluster_id
// m_axis  | out | tdata: pixel_u, pixel_v, in_front; tuser: cluster_tag
// cfg     | in  | cfg_index_i (register), cfg_data_i
//
// One point per cycle while the chain is not stalled; the stages are the input register, 2 transform
// stages, 2 setup stages, 15 divider cells, one pass stage and the output stage.
// The whole chain advances when the output register is free or taken.
// Reset clears the valid bits and loads the default intrinsics.
`timescale 1ns / 1ps
`include "lidar_point_to_pixel_projection_unit_defines.svh"
module lidar_point_to_pixel_projection_unit import lpp_pkg::*; #(
  parameter int unsigned CLUSTER_ID_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // point_x, point_y, point_z
  input  logic [CLUSTER_ID_BITS-1:0] s_axis_tuser, // cluster_id
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // pixel_u, pixel_v, in_front, zero fill
  output logic [CLUSTER_ID_BITS-1:0] m_axis_tuser, // cluster_tag
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  localparam int unsigned Depth = 3 + 2 + PixW + 1;

  logic en;
  logic [Depth-1:0] vld_q;
  logic [CLUSTER_ID_BITS-1:0] tag_q [Depth];
  logic [RegW-1:0] fx_q, fy_q, cx_q, cy_q;

  assign en = !vld_q[Depth-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_q <= 28'd90831190;
      fy_q <= 28'd90540299;
      cx_q <= 28'd61356418;
      cy_q <= 28'd32413756;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_FOCAL_X:  fx_q <= cfg_data_i[RegW-1:0];
        REG_FOCAL_Y:  fy_q <= cfg_data_i[RegW-1:0];
        REG_CENTER_X: cx_q <= cfg_data_i[RegW-1:0];
        REG_CENTER_Y: cy_q <= cfg_data_i[RegW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      tag_q[0] <= s_axis_tuser;
      for (int i = 1; i < Depth; i++) tag_q[i] <= tag_q[i-1];
    end
  end

  // stage 0: register input
  logic signed [31:0] px_q, py_q, pz_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= s_axis_tdata[31:0];
      py_q <= s_axis_tdata[63:32];
      pz_q <= s_axis_tdata[95:64];
    end
  end
  logic signed [33:0] xc, yc, zc;
  lpp_xform u_xform (.clk_i, .en_i(en), .px_i(px_q), .py_i(py_q), .pz_i(pz_q),
                     .xc_o(xc), .yc_o(yc), .zc_o(zc));

  // setup stage A: numerators (f*x + c*z) with products registered
  logic signed [63:0] nfu_q, ncu_q, nfv_q, ncv_q;
  logic signed [33:0] za_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      nfu_q <= 64'($signed({1'b0, fx_q}) * xc);
      nfv_q <= 64'($signed({1'b0, fy_q}) * yc);
      ncu_q <= 64'($signed({1'b0, cx_q}) * zc);
      ncv_q <= 64'($signed({1'b0, cy_q}) * zc);
      za_q  <= zc;
    end
  end
  // setup stage B: magnitudes, sign, saturation check
  lane_t ln_u_b, ln_v_b;
  logic front_q [PixW+1];
  logic [48:0] den_q [PixW-1];
  logic signed [64:0] nu, nv;
  logic [64:0] mu, mv;
  logic [48:0] den;
  logic frontb;
  always_comb begin
    frontb = (za_q > 0);
    den = 49'(za_q) << CoordFracBits;
    nu = 65'(nfu_q) + 65'(ncu_q);
    nv = 65'(nfv_q) + 65'(ncv_q);
    mu = nu[64] ? 65'(-nu) : 65'(nu);
    mv = nv[64] ? 65'(-nv) : 65'(nv);
    ln_u_b.neg = nu[64];
    ln_v_b.neg = nv[64];
    ln_u_b.quo = '0;
    ln_v_b.quo = '0;
    ln_u_b.sat = !frontb || (mu >= (65'(den) << 15));
    ln_v_b.sat = !frontb || (mv >= (65'(den) << 15));
    ln_u_b.rem = 63'(mu);
    ln_v_b.rem = 63'(mv);
  end
  lane_t lu [PixW+1];
  lane_t lv [PixW+1];
  always_ff @(posedge clk_i) begin
    if (en) begin
      lu[0] <= ln_u_b;
      lv[0] <= ln_v_b;
      den_q[0] <= den;
      for (int i = 1; i < PixW - 1; i++) den_q[i] <= den_q[i-1];
      front_q[0] <= frontb;
      for (int i = 1; i <= PixW; i++) front_q[i] <= front_q[i-1];
    end
  end
  genvar g;
  for (g = 0; g < PixW - 1; g++) begin : g_cells
    lpp_div_cell #(.Shift(PixW-2-g)) u_cu (.clk_i, .en_i(en), .lane_i(lu[g]),
      .den_i(den_q[g]), .lane_o(lu[g+1]));
    lpp_div_cell #(.Shift(PixW-2-g)) u_cv (.clk_i, .en_i(en), .lane_i(lv[g]),
      .den_i(den_q[g]), .lane_o(lv[g+1]));
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      lu[PixW] <= lu[PixW-1];
      lv[PixW] <= lv[PixW-1];
    end
  end

  // output: sign, saturation, behind camera forcing
  function automatic logic [15:0] fin(lane_t l, logic f);
    logic [15:0] r;
    r = '0;
    if (f) begin
      if (l.sat) r = l.neg ? 16'h8000 : 16'h7FFF;
      else r = l.neg ? 16'(-l.quo) : l.quo;
    end
    return r;
  endfunction
  logic [15:0] pu_q, pv_q;
  logic fr_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      pu_q <= fin(lu[PixW], front_q[PixW]);
      pv_q <= fin(lv[PixW], front_q[PixW]);
      fr_q <= front_q[PixW];
    end
  end
  assign m_axis_tvalid = vld_q[Depth-1];
  assign m_axis_tdata = {7'd0, fr_q, pv_q, pu_q};
  assign m_axis_tuser = tag_q[Depth-1];

  `LPP_ASSERT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")
  `LPP_ASSERT(a_rdy, clk_i, rst_ni, !m_axis_tvalid |-> s_axis_tready, "stall without result")
  `LPP_ASSERT(a_back, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[32] |-> m_axis_tdata[31:0] == 32'd0, "behind camera pixel not zero")
endmodule
